/* sv/desa_pkg.sv */
`default_nettype none

package desa_pkg;

    localparam int REGION_BYTES_MAX_DEF = 65536;
    localparam int CAP_W  = 17;
    localparam int ADDR_W = 32;
    localparam int CNT_W  = 32;
    localparam int ALN_W  = 13;
    localparam logic [CAP_W-1:0] CAP_RESET = 17'd65536;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE     = 1'd1;
    localparam logic SIDE_FRONT = 1'b0;
    localparam logic SIDE_BACK  = 1'b1;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_MARK  = 2'd1,
        OP_RESET = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef struct packed {
        t_op              op;
        logic             side;
        logic [CAP_W-1:0] request_size;
        logic [ALN_W-1:0] align_bytes;
    } t_in_req;

    typedef struct packed {
        logic              granted;
        logic [ADDR_W-1:0] block_address;
        logic [CAP_W-1:0]  front_used;
        logic [CAP_W-1:0]  back_start;
        logic [CNT_W-1:0]  bytes_needed;
        logic [CNT_W-1:0]  call_count;
    } t_out_res;

    typedef struct packed {
        logic              ok;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] pad;
        logic [CAP_W-1:0]  front_nxt;
        logic [CAP_W-1:0]  back_nxt;
    } t_alloc_res;

endpackage

`default_nettype wire

/* sv/desa_alloc.sv */
`default_nettype none

module desa_alloc #(
    parameter int OFS_W = 17
) (
    input  desa_pkg::t_in_req              i_req,
    input  logic [OFS_W-1:0]               i_front,
    input  logic [OFS_W-1:0]               i_back,
    input  logic [desa_pkg::ADDR_W-1:0]    i_base,
    output desa_pkg::t_alloc_res           o_res
);

    logic [desa_pkg::ADDR_W-1:0] m;
    logic [desa_pkg::ADDR_W-1:0] uf, memf, padf;
    logic [desa_pkg::ADDR_W-1:0] ub, memb, padb;
    logic [desa_pkg::ADDR_W:0]   totf, totb, take;
    logic                        fullf, fullb, full;

    always_comb begin
        m = (i_req.align_bytes != '0) ?
            (desa_pkg::ADDR_W'(i_req.align_bytes) - 32'd1) : '0;

        uf   = i_base + desa_pkg::ADDR_W'(i_front);
        memf = (uf + m) & ~m;
        padf = memf - uf;
        totf = 33'(i_req.request_size) + 33'(padf);
        fullf = (34'(i_front) + 34'(totf)) > 34'(i_back);

        ub   = i_base + desa_pkg::ADDR_W'(i_back) - desa_pkg::ADDR_W'(i_req.request_size);
        memb = ub & ~m;
        padb = ub - memb;
        totb = 33'(i_req.request_size) + 33'(padb);
        take = (totb < 33'(i_back)) ? totb : 33'(i_back);
        fullb = (33'(i_back) - take) <= 33'(i_front);

        full = (i_req.side == desa_pkg::SIDE_BACK) ? fullb : fullf;

        o_res.ok        = (i_req.request_size != '0) && !full;
        o_res.addr      = (i_req.side == desa_pkg::SIDE_BACK) ? memb : memf;
        o_res.pad       = (i_req.side == desa_pkg::SIDE_BACK) ? padb : padf;
        o_res.front_nxt = desa_pkg::CAP_W'(34'(i_front) + 34'(totf));
        o_res.back_nxt  = desa_pkg::CAP_W'(33'(i_back) - totb);
    end

endmodule

`default_nettype wire

/* sv/double_ended_stack_allocator.sv */
// channel | direction | handshake                   | payload
// request | in        | i_in_valid / o_in_stall     | i_in_req  (desa_pkg::t_in_req)
// result  | out       | o_out_valid / i_out_stall   | o_out_res (desa_pkg::t_out_res)
// config  | in        | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
// One request per cycle while the result is not stalled; a request passes the input register, then the result register.
// Offsets, markers and counters update when a request moves into the result register.
// A stalled result holds; the input register still fills behind it, then stalls.
// Reset and any config write restore empty sides, zero counters, inactive markers.
`default_nettype none

module double_ended_stack_allocator #(
    parameter int REGION_BYTES_MAX = desa_pkg::REGION_BYTES_MAX_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  desa_pkg::t_in_req                   i_in_req,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output desa_pkg::t_out_res                  o_out_res,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [desa_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [desa_pkg::ADDR_W-1:0]         i_cfg_data
);

    localparam int CAP_MAXV  = (1 << desa_pkg::CAP_W) - 1;
    localparam int CAP_LIMIT = (REGION_BYTES_MAX < CAP_MAXV) ? REGION_BYTES_MAX : CAP_MAXV;
    localparam int OFS_W     = $clog2(CAP_LIMIT + 1);
    localparam logic [desa_pkg::CAP_W-1:0] CAP_LIM_V = desa_pkg::CAP_W'(CAP_LIMIT);
    localparam logic [OFS_W-1:0] CAP_RST_V =
        (desa_pkg::CAP_RESET > CAP_LIM_V) ? OFS_W'(CAP_LIM_V) : OFS_W'(desa_pkg::CAP_RESET);

    logic                        r_in_vld, r_out_vld;
    desa_pkg::t_in_req           r_in_req;
    desa_pkg::t_out_res          r_out_res, n_out_res;
    logic [OFS_W-1:0]            r_cap, r_front, r_back, n_front, n_back;
    logic [OFS_W-1:0]            r_mark [2];
    logic [OFS_W-1:0]            n_mark [2];
    logic [1:0]                  r_mact, n_mact;
    logic [desa_pkg::ADDR_W-1:0] r_base;
    logic [desa_pkg::CNT_W-1:0]  r_need, r_calls, n_need, n_calls;
    logic                        in_acc, out_adv, cfg_wr;
    logic [desa_pkg::CAP_W-1:0]  cfg_cap;
    desa_pkg::t_alloc_res        alloc;

    assign out_adv     = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall  = r_in_vld && !out_adv;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = !r_in_vld;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign cfg_cap     = i_cfg_data[desa_pkg::CAP_W-1:0];
    assign o_out_valid = r_out_vld;
    assign o_out_res   = r_out_res;

    desa_alloc #(
        .OFS_W(OFS_W)
    ) u_alloc (
        .i_req   (r_in_req),
        .i_front (r_front),
        .i_back  (r_back),
        .i_base  (r_base),
        .o_res   (alloc)
    );

    always_comb begin
        n_front  = r_front;
        n_back   = r_back;
        n_need   = r_need;
        n_calls  = r_calls;
        n_mark   = r_mark;
        n_mact   = r_mact;
        n_out_res = '0;
        n_out_res.granted = 1'b1;
        case (r_in_req.op)
            desa_pkg::OP_ALLOC: begin
                n_out_res.granted = alloc.ok;
                if (r_in_req.request_size != '0) begin
                    n_need = r_need + desa_pkg::CNT_W'(r_in_req.request_size);
                end
                if (alloc.ok) begin
                    n_need  = r_need + desa_pkg::CNT_W'(r_in_req.request_size) + alloc.pad;
                    n_calls = r_calls + 32'd1;
                    n_out_res.block_address = alloc.addr;
                    if (r_in_req.side == desa_pkg::SIDE_BACK) begin
                        n_back = OFS_W'(alloc.back_nxt);
                    end else begin
                        n_front = OFS_W'(alloc.front_nxt);
                    end
                end
            end
            desa_pkg::OP_MARK: begin
                n_mact[r_in_req.side] = 1'b1;
                n_mark[r_in_req.side] =
                    (r_in_req.side == desa_pkg::SIDE_BACK) ? r_back : r_front;
            end
            desa_pkg::OP_RESET: begin
                if (r_in_req.side == desa_pkg::SIDE_BACK) begin
                    n_need = r_need - (desa_pkg::CNT_W'(r_cap) - desa_pkg::CNT_W'(r_mark[1]));
                    n_back = r_mact[1] ? r_mark[1] : r_cap;
                end else begin
                    n_need  = r_need - (desa_pkg::CNT_W'(r_front) - desa_pkg::CNT_W'(r_mark[0]));
                    n_front = r_mact[0] ? r_mark[0] : '0;
                end
                n_mact[r_in_req.side] = 1'b0;
            end
            desa_pkg::OP_CLEAR: begin
                n_front = '0;
                n_back  = r_cap;
                n_need  = '0;
                n_calls = '0;
            end
            default: begin
                n_out_res.granted = 1'b0;
            end
        endcase
        n_out_res.front_used   = desa_pkg::CAP_W'(n_front);
        n_out_res.back_start   = desa_pkg::CAP_W'(n_back);
        n_out_res.bytes_needed = n_need;
        n_out_res.call_count   = n_calls;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_cap     <= CAP_RST_V;
            r_base    <= '0;
            r_front   <= '0;
            r_back    <= CAP_RST_V;
            r_need    <= '0;
            r_calls   <= '0;
            r_mark[0] <= '0;
            r_mark[1] <= '0;
            r_mact    <= '0;
        end else begin
            if (in_acc) begin
                r_in_vld <= 1'b1;
            end else if (out_adv) begin
                r_in_vld <= 1'b0;
            end
            if (out_adv) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            if (cfg_wr) begin
                r_front   <= '0;
                r_need    <= '0;
                r_calls   <= '0;
                r_mark[0] <= '0;
                r_mark[1] <= '0;
                r_mact    <= '0;
                if (i_cfg_index == desa_pkg::CFG_CAPACITY) begin
                    r_cap  <= (cfg_cap > CAP_LIM_V) ? OFS_W'(CAP_LIM_V) : OFS_W'(cfg_cap);
                    r_back <= (cfg_cap > CAP_LIM_V) ? OFS_W'(CAP_LIM_V) : OFS_W'(cfg_cap);
                end else begin
                    r_base <= i_cfg_data;
                    r_back <= r_cap;
                end
            end else if (out_adv) begin
                r_front <= n_front;
                r_back  <= n_back;
                r_need  <= n_need;
                r_calls <= n_calls;
                r_mark  <= n_mark;
                r_mact  <= n_mact;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_req <= i_in_req;
        end
        if (out_adv) begin
            r_out_res <= n_out_res;
        end
    end

    a_front_in_region: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_front <= r_cap) && (r_back <= r_cap))
        else $error("offset beyond region");

    a_addr_only_granted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_out_res.block_address != '0)) |-> r_out_res.granted)
        else $error("address on a failed request");

    a_cfg_reinit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr |=> ((r_front == '0) && (r_calls == '0) && (r_mact == 2'b00)))
        else $error("config write did not reinitialize");

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_vld && r_out_vld))
        else $error("stall with no pending request");

endmodule

`default_nettype wire

/* tb/double_ended_stack_allocator_tb.sv */
module double_ended_stack_allocator_tb;

    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_in_valid = 1'b0;
    logic                                o_in_stall;
    desa_pkg::t_in_req                   i_in_req = '0;
    logic                                o_out_valid;
    logic                                i_out_stall = 1'b0;
    desa_pkg::t_out_res                  o_out_res;
    logic                                i_cfg_valid = 1'b0;
    logic                                o_cfg_ready;
    logic [desa_pkg::CFG_IDX_W-1:0]      i_cfg_index = desa_pkg::CFG_CAPACITY;
    logic [desa_pkg::ADDR_W-1:0]         i_cfg_data = '0;

    double_ended_stack_allocator DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_res   (o_out_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // allocator shadow state
    bit [16:0] shd_cap_reg;
    bit [31:0] shd_base;
    bit [63:0] shd_cap;
    bit [63:0] shd_front;
    bit [63:0] shd_back;
    bit [31:0] shd_needed;
    bit [31:0] shd_grants;
    bit [63:0] shd_mark [2];
    bit        shd_mark_on [2];

    desa_pkg::t_out_res pending_results[$];
    int       mismatches = 0;
    int       results_seen = 0;
    bit       idle_on = 1'b1;
    int       hold_asked = 0;
    int       hold_taken = 0;
    int       hold_left = 0;
    int       burst_left = 0;
    int       quiet_cycles = 0;

    task automatic clear_allocator();
        shd_cap = (shd_cap_reg > 17'd65536) ? 64'd65536 : {47'd0, shd_cap_reg};
        shd_front = '0;
        shd_back = shd_cap;
        shd_needed = '0;
        shd_grants = '0;
        shd_mark[0] = '0;
        shd_mark[1] = '0;
        shd_mark_on[0] = 1'b0;
        shd_mark_on[1] = 1'b0;
    endtask

    function automatic desa_pkg::t_out_res step_allocator(input desa_pkg::t_in_req req);
        desa_pkg::t_out_res res;
        bit [31:0] sz32, al32, m, u, mem, pad;
        bit [63:0] tot, take;
        bit        full;
        res = '0;
        res.granted = 1'b1;
        sz32 = 32'(req.request_size);
        al32 = 32'(req.align_bytes);
        case (req.op)
            desa_pkg::OP_ALLOC: begin
                res.granted = 1'b0;
                if (sz32 != 0) begin
                    m = (al32 != 0) ? al32 - 32'd1 : 32'd0;
                    shd_needed = shd_needed + sz32;
                    if (req.side == desa_pkg::SIDE_FRONT) begin
                        u = shd_base + shd_front[31:0];
                        mem = (u + m) & ~m;
                        pad = mem - u;
                        tot = {32'd0, sz32} + {32'd0, pad};
                        full = (shd_front + tot) > shd_back;
                    end else begin
                        u = shd_base + shd_back[31:0] - sz32;
                        mem = u & ~m;
                        pad = u - mem;
                        tot = {32'd0, sz32} + {32'd0, pad};
                        take = (tot < shd_back) ? tot : shd_back;
                        full = (shd_back - take) <= shd_front;
                    end
                    if (!full) begin
                        if (req.side == desa_pkg::SIDE_FRONT) shd_front = shd_front + tot;
                        else shd_back = shd_back - tot;
                        shd_needed = shd_needed + pad;
                        shd_grants = shd_grants + 32'd1;
                        res.granted = 1'b1;
                        res.block_address = mem;
                    end
                end
            end
            desa_pkg::OP_MARK: begin
                shd_mark_on[req.side] = 1'b1;
                shd_mark[req.side] = (req.side == desa_pkg::SIDE_BACK) ? shd_back : shd_front;
            end
            desa_pkg::OP_RESET: begin
                if (req.side == desa_pkg::SIDE_BACK) begin
                    shd_needed = shd_needed - (shd_cap[31:0] - shd_mark[1][31:0]);
                    shd_back = shd_mark_on[1] ? shd_mark[1] : shd_cap;
                end else begin
                    shd_needed = shd_needed - (shd_front[31:0] - shd_mark[0][31:0]);
                    shd_front = shd_mark_on[0] ? shd_mark[0] : 64'd0;
                end
                shd_mark_on[req.side] = 1'b0;
            end
            default: begin
                shd_front = '0;
                shd_back = shd_cap;
                shd_grants = '0;
                shd_needed = '0;
            end
        endcase
        res.front_used = shd_front[16:0];
        res.back_start = shd_back[16:0];
        res.bytes_needed = shd_needed;
        res.call_count = shd_grants;
        return res;
    endfunction

    task automatic issue_request(input desa_pkg::t_op op, input logic side,
                                 input int size, input int align);
        desa_pkg::t_in_req req;
        req.op = op;
        req.side = side;
        req.request_size = size[16:0];
        req.align_bytes = align[12:0];
        if (idle_on && $urandom_range(0, 9) == 0) begin
            @(negedge i_clk) i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 16) - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_req <= req;
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(step_allocator(req));
    endtask

    task automatic wait_idle();
        @(negedge i_clk) i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [desa_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [31:0] data);
        wait_idle();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == desa_pkg::CFG_CAPACITY) shd_cap_reg = data[16:0];
        else shd_base = data;
        clear_allocator();
        @(negedge i_clk) i_cfg_valid <= 1'b0;
    endtask

    task automatic random_request();
        int            r, sz, al, cap, lim_s, lim_m;
        desa_pkg::t_op op;
        logic          side;
        cap = int'(shd_cap);
        lim_s = (cap / 32 > 0) ? cap / 32 : 1;
        lim_m = (cap / 4 > 0) ? cap / 4 : 1;
        r = $urandom_range(0, 99);
        if (r < 68) op = desa_pkg::OP_ALLOC;
        else if (r < 80) op = desa_pkg::OP_MARK;
        else if (r < 93) op = desa_pkg::OP_RESET;
        else op = desa_pkg::OP_CLEAR;
        side = 1'($urandom_range(0, 1));
        r = $urandom_range(0, 99);
        if (r < 50) sz = $urandom_range(1, lim_s);
        else if (r < 80) sz = $urandom_range(1, lim_m);
        else if (r < 88) sz = 0;
        else if (r < 94) sz = 65536;
        else sz = $urandom_range(0, 65536);
        r = $urandom_range(0, 99);
        if (r < 30) al = 0;
        else if (r < 85) al = 1 << $urandom_range(0, 12);
        else al = $urandom_range(0, 4096);
        issue_request(op, side, sz, al);
    endtask

    task automatic test_alloc_basics();
        issue_request(desa_pkg::OP_ALLOC, desa_pkg::SIDE_FRONT, 0, 0);
        issue_request(desa_pkg::OP_ALLOC, desa_pkg::SIDE_FRONT, 1, 0);
        issue_request(desa_pkg::OP_ALLOC, desa_pkg::SIDE_FRONT, 3, 4096);
        issue_request(desa_pkg::OP_ALLOC, desa_pkg::SIDE_BACK, 5, 8);
        issue_request(desa_pkg::OP_ALLOC, desa_pkg::SIDE_FRONT, 7, 3);
        issue_request(desa_pkg::OP_ALLOC, desa_pkg::SIDE_BACK, 65536, 1);
        issue_request(desa_pkg::OP_CLEAR, desa_pkg::SIDE_BACK, 65536, 4096);
        issue_request(desa_pkg::OP_ALLOC, desa_pkg::SIDE_FRONT, 65536, 4096);
        issue_request(desa_pkg::OP_ALLOC, desa_pkg::SIDE_BACK, 1, 0);
        issue_request(desa_pkg::OP_CLEAR, desa_pkg::SIDE_FRONT, 0, 0);
        issue_request(desa_pkg::OP_ALLOC, desa_pkg::SIDE_BACK, 65535, 0);
        issue_request(desa_pkg::OP_CLEAR, desa_pkg::SIDE_FRONT, 0, 0);
    endtask

    task automatic test_markers();
        issue_request(desa_pkg::OP_MARK, desa_pkg::SIDE_FRONT, 0, 0);
        issue_request(desa_pkg::OP_ALLOC, desa_pkg::SIDE_FRONT, 100, 16);
        issue_request(desa_pkg::OP_RESET, desa_pkg::SIDE_FRONT, 0, 0);
        issue_request(desa_pkg::OP_RESET, desa_pkg::SIDE_FRONT, 0, 0);
        issue_request(desa_pkg::OP_MARK, desa_pkg::SIDE_BACK, 0, 0);
        issue_request(desa_pkg::OP_ALLOC, desa_pkg::SIDE_BACK, 200, 16);
        issue_request(desa_pkg::OP_RESET, desa_pkg::SIDE_BACK, 0, 0);
        issue_request(desa_pkg::OP_RESET, desa_pkg::SIDE_BACK, 0, 0);
    endtask

    // front marker left above a later back end
    task automatic test_stale_marker();
        issue_request(desa_pkg::OP_ALLOC, desa_pkg::SIDE_FRONT, 1000, 0);
        issue_request(desa_pkg::OP_MARK, desa_pkg::SIDE_FRONT, 0, 0);
        issue_request(desa_pkg::OP_CLEAR, desa_pkg::SIDE_FRONT, 0, 0);
        issue_request(desa_pkg::OP_ALLOC, desa_pkg::SIDE_BACK, 65000, 0);
        issue_request(desa_pkg::OP_RESET, desa_pkg::SIDE_FRONT, 0, 0);
        issue_request(desa_pkg::OP_ALLOC, desa_pkg::SIDE_FRONT, 1, 0);
        issue_request(desa_pkg::OP_ALLOC, desa_pkg::SIDE_BACK, 1, 0);
        issue_request(desa_pkg::OP_CLEAR, desa_pkg::SIDE_BACK, 0, 0);
    endtask

    task automatic test_register_extremes();
        write_register(desa_pkg::CFG_CAPACITY, 32'd1);
        write_register(desa_pkg::CFG_BASE, 32'hFFFF_FFFF);
        issue_request(desa_pkg::OP_ALLOC, desa_pkg::SIDE_FRONT, 1, 0);
        issue_request(desa_pkg::OP_ALLOC, desa_pkg::SIDE_BACK, 1, 0);
        issue_request(desa_pkg::OP_CLEAR, desa_pkg::SIDE_FRONT, 0, 0);
        issue_request(desa_pkg::OP_ALLOC, desa_pkg::SIDE_BACK, 1, 4096);
        issue_request(desa_pkg::OP_ALLOC, desa_pkg::SIDE_FRONT, 1, 4096);
        write_register(desa_pkg::CFG_CAPACITY, 32'd65536);
        write_register(desa_pkg::CFG_BASE, 32'hFFFF_FFF0);
        issue_request(desa_pkg::OP_ALLOC, desa_pkg::SIDE_FRONT, 1, 4096);
        issue_request(desa_pkg::OP_ALLOC, desa_pkg::SIDE_BACK, 17, 4096);
        wait_idle();
    endtask

    task automatic test_backpressure();
        hold_asked = hold_asked + 1;
        repeat (60) random_request();
        wait_idle();
    endtask

    task automatic test_random_phases();
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    write_register(desa_pkg::CFG_CAPACITY, 32'd16);
                    write_register(desa_pkg::CFG_BASE, $urandom);
                end
                1: begin
                    write_register(desa_pkg::CFG_CAPACITY, 32'd4096);
                    write_register(desa_pkg::CFG_BASE, 32'h0000_1003);
                end
                2: begin
                    write_register(desa_pkg::CFG_CAPACITY, 32'd65536);
                    write_register(desa_pkg::CFG_BASE, 32'd0);
                end
                3: begin
                    write_register(desa_pkg::CFG_CAPACITY, $urandom_range(1, 65536));
                    write_register(desa_pkg::CFG_BASE, 32'hFFFF_F000);
                end
                default: begin
                    write_register(desa_pkg::CFG_CAPACITY, $urandom_range(1, 256));
                    write_register(desa_pkg::CFG_BASE, $urandom);
                end
            endcase
            repeat (280) random_request();
        end
        wait_idle();
    endtask

    task automatic test_steady_stream();
        idle_on = 1'b0;
        write_register(desa_pkg::CFG_CAPACITY, $urandom_range(1, 65536));
        write_register(desa_pkg::CFG_BASE, $urandom);
        repeat (300) random_request();
        wait_idle();
    endtask

    always @(negedge i_clk) begin
        if (hold_left == 0 && hold_taken != hold_asked) begin
            hold_taken = hold_taken + 1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (burst_left != 0) begin
            burst_left = burst_left - 1;
            i_out_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 11) == 0) begin
            burst_left = $urandom_range(1, 16) - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        desa_pkg::t_out_res want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen = results_seen + 1;
            if (pending_results.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("unexpected result %0d: %h", results_seen, o_out_res);
            end else begin
                want = pending_results.pop_front();
                if (o_out_res.granted !== want.granted ||
                    o_out_res.block_address !== want.block_address ||
                    o_out_res.front_used !== want.front_used ||
                    o_out_res.back_start !== want.back_start ||
                    o_out_res.bytes_needed !== want.bytes_needed ||
                    o_out_res.call_count !== want.call_count) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display({"result %0d mismatch: exp g=%0d addr=%h front=%0d back=%0d ",
                                  "need=%h calls=%h / got g=%0d addr=%h front=%0d back=%0d ",
                                  "need=%h calls=%h"},
                                 results_seen, want.granted, want.block_address,
                                 want.front_used, want.back_start, want.bytes_needed,
                                 want.call_count, o_out_res.granted, o_out_res.block_address,
                                 o_out_res.front_used, o_out_res.back_start,
                                 o_out_res.bytes_needed, o_out_res.call_count);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles = quiet_cycles + 1;
                if (quiet_cycles >= STALL_LIMIT) begin
                    $display("double_ended_stack_allocator regression: fail");
                    $finish;
                end
            end
        end
    end

    initial begin
        shd_cap_reg = 17'd65536;
        shd_base = '0;
        clear_allocator();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;
        test_alloc_basics();
        test_markers();
        test_stale_marker();
        test_register_extremes();
        test_backpressure();
        test_random_phases();
        test_steady_stream();
        @(negedge i_clk) i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("double_ended_stack_allocator regression: pass");
        end else begin
            $display("double_ended_stack_allocator regression: fail");
        end
        $finish;
    end

endmodule
